@@ src/ksl_pkg.sv @@
// Package for the k smallest sorted list block.
// Holds the shared constants and the control struct that the top level hands to each cell.
// Depends on nothing.
`default_nettype none

package ksl_pkg;

	localparam int MAX_KEEP_DEF  = 10;
	localparam int ID_BITS_DEF   = 16;
	localparam int DIST_BITS_DEF = 32;

	localparam int KEEP_BITS = 4;
	localparam int RANK_BITS = 4;

	localparam logic [KEEP_BITS-1:0] KEEP_RESET = 4'd10;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/ksl_if.sv @@
// Channel interfaces for the k smallest sorted list block.
// Uses ksl_pkg for the rank width.
`default_nettype none

interface ksl_in_if #(
	parameter int ID_BITS   = ksl_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = ksl_pkg::DIST_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [ID_BITS-1:0]   record_id;
	logic [DIST_BITS-1:0] distance;
	logic                 first_item;
	logic                 last_item;

	modport source (output valid, record_id, distance, first_item, last_item, input ready);
	modport sink (input valid, record_id, distance, first_item, last_item, output ready);
endinterface

interface ksl_out_if #(
	parameter int ID_BITS   = ksl_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = ksl_pkg::DIST_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [ksl_pkg::RANK_BITS-1:0]  rank;
	logic [ID_BITS-1:0]             kept_id;
	logic [DIST_BITS-1:0]           kept_distance;
	logic                           final_entry;

	modport source (output valid, rank, kept_id, kept_distance, final_entry, input ready);
	modport sink (input valid, rank, kept_id, kept_distance, final_entry, output ready);
endinterface

`default_nettype wire

@@ src/ksl_cell.sv @@
// One cell of the sorted list: holds one entry, compares it with the offered distance
// and takes data from its neighbours on an insert or a rotation. Depends on ksl_pkg.
`default_nettype none

module ksl_cell #(
	parameter int INDEX     = 0,
	parameter int ID_BITS   = ksl_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = ksl_pkg::DIST_BITS_DEF,
	parameter int CW        = 4
) (
	input  wire logic                   clk,
	input  wire ksl_pkg::cell_ctl_t     ctl,
	input  wire logic [CW-1:0]          fill,
	input  wire logic [CW-1:0]          cap,
	input  wire logic [ID_BITS-1:0]     new_id,
	input  wire logic [DIST_BITS-1:0]   new_dist,
	input  wire logic                   prev_lt,
	input  wire logic [ID_BITS-1:0]     prev_id,
	input  wire logic [DIST_BITS-1:0]   prev_dist,
	input  wire logic [ID_BITS-1:0]     next_id,
	input  wire logic [DIST_BITS-1:0]   next_dist,
	input  wire logic [ID_BITS-1:0]     head_id,
	input  wire logic [DIST_BITS-1:0]   head_dist,
	output logic                        lt,
	output logic [ID_BITS-1:0]          id,
	output logic [DIST_BITS-1:0]        entry_dist
);

	localparam logic [CW-1:0] IDX      = CW'(INDEX);
	localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

	logic [ID_BITS-1:0]   id_q;
	logic [DIST_BITS-1:0] dist_q;

	// The new entry lands in the first cell whose distance is strictly larger, or in the
	// first empty cell when the list still has room.
	always_comb begin
		lt = (IDX < fill) && (new_dist < dist_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (!prev_lt && (lt || ((IDX == fill) && (fill < cap)))) begin
				id_q   <= new_id;
				dist_q <= new_dist;
			end else if (prev_lt && (IDX < cap)) begin
				id_q   <= prev_id;
				dist_q <= prev_dist;
			end
		end else if (ctl.rotate) begin
			if (IDX_NEXT < fill) begin
				id_q   <= next_id;
				dist_q <= next_dist;
			end else if (IDX_NEXT == fill) begin
				id_q   <= head_id;
				dist_q <= head_dist;
			end
		end
	end

	assign id         = id_q;
	assign entry_dist = dist_q;

endmodule

`default_nettype wire

@@ src/k_smallest_sorted_list.sv @@
// Top level of the k smallest sorted list block: a chain of list cells with fill and
// emission control. Depends on ksl_pkg, ksl_if and ksl_cell.
//
// The candidate channel offers a record id and a distance; a request is taken when valid
// and ready are both high. A request marked first empties the list before its entry is
// added. To place the entry, every cell compares the offered distance with its own entry
// in parallel and takes the new entry or its upper neighbour's or keeps its own. A
// request marked last then starts emission on the result channel: the list rotates one
// cell a cycle towards the head while the receiver does not stall, and the head entry is
// loaded into the output register with its rank; once the whole list has left, it is back
// in its original order. After the last request is taken, emission starts and registers
// the first result. Candidate ready is low while emission runs; other requests are taken
// one per cycle. A stall on the result channel holds the output register and the rotation.
// keep_count is written through cfg_write and cfg_wdata while the block is idle, a rule
// for the user that the block itself does not enforce. Reset empties the list, clears
// emission and sets keep_count to ten; the stored entries themselves are not cleared.
`default_nettype none

module k_smallest_sorted_list #(
	parameter int MAX_KEEP  = ksl_pkg::MAX_KEEP_DEF,
	parameter int ID_BITS   = ksl_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = ksl_pkg::DIST_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [ksl_pkg::KEEP_BITS-1:0]    cfg_wdata,
	ksl_in_if.sink                                candidate,
	ksl_out_if.source                             result
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int KW = (CW > ksl_pkg::KEEP_BITS) ? CW : ksl_pkg::KEEP_BITS;
	localparam logic [CW-1:0] MAX_FILL = CW'(MAX_KEEP);

	logic [ksl_pkg::KEEP_BITS-1:0] keep_q;
	logic [CW-1:0]                 fill_q;
	logic                          emit_q;
	logic [CW-1:0]                 rank_q;
	logic                          out_valid_q;
	logic [ksl_pkg::RANK_BITS-1:0] out_rank_q;
	logic [ID_BITS-1:0]            out_id_q;
	logic [DIST_BITS-1:0]          out_dist_q;
	logic                          out_final_q;

	logic [KW-1:0]         keep_ext;
	logic [KW-1:0]         rank_ext;
	logic [CW-1:0]         cap;
	logic [CW-1:0]         fill_now;
	logic [CW-1:0]         fill_next;
	logic [CW-1:0]         cell_fill;
	logic                  accept;
	logic                  step;
	logic                  step_final;
	ksl_pkg::cell_ctl_t    ctl;

	logic [MAX_KEEP-1:0]  cell_lt;
	logic [ID_BITS-1:0]   cell_id   [MAX_KEEP];
	logic [DIST_BITS-1:0] cell_dist [MAX_KEEP];

	always_comb begin
		keep_ext = KW'(keep_q);
		if (keep_q == '0) begin
			cap = CW'(1);
		end else if (keep_ext > KW'(MAX_KEEP)) begin
			cap = MAX_FILL;
		end else begin
			cap = CW'(keep_ext);
		end

		if (candidate.first_item) begin
			fill_now = '0;
		end else if (fill_q > cap) begin
			fill_now = cap;
		end else begin
			fill_now = fill_q;
		end
		fill_next = (fill_now < cap) ? fill_now + CW'(1) : fill_now;

		accept     = candidate.valid && candidate.ready;
		step       = emit_q && (!out_valid_q || result.ready);
		step_final = (rank_q + CW'(1)) == fill_q;
		rank_ext   = KW'(rank_q);

		ctl.insert = accept;
		ctl.rotate = step;
		cell_fill  = accept ? fill_now : fill_q;
	end

	assign candidate.ready = !emit_q;

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		logic                 prev_lt;
		logic [ID_BITS-1:0]   prev_id;
		logic [DIST_BITS-1:0] prev_dist;
		logic [ID_BITS-1:0]   next_id;
		logic [DIST_BITS-1:0] next_dist;

		if (i == 0) begin : g_head
			assign prev_lt   = 1'b0;
			assign prev_id   = candidate.record_id;
			assign prev_dist = candidate.distance;
		end else begin : g_body
			assign prev_lt   = cell_lt[i-1];
			assign prev_id   = cell_id[i-1];
			assign prev_dist = cell_dist[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign next_id   = cell_id[i];
			assign next_dist = cell_dist[i];
		end else begin : g_inner
			assign next_id   = cell_id[i+1];
			assign next_dist = cell_dist[i+1];
		end

		ksl_cell #(
			.INDEX     (i),
			.ID_BITS   (ID_BITS),
			.DIST_BITS (DIST_BITS),
			.CW        (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.fill       (cell_fill),
			.cap        (cap),
			.new_id     (candidate.record_id),
			.new_dist   (candidate.distance),
			.prev_lt    (prev_lt),
			.prev_id    (prev_id),
			.prev_dist  (prev_dist),
			.next_id    (next_id),
			.next_dist  (next_dist),
			.head_id    (cell_id[0]),
			.head_dist  (cell_dist[0]),
			.lt         (cell_lt[i]),
			.id         (cell_id[i]),
			.entry_dist (cell_dist[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q      <= ksl_pkg::KEEP_RESET;
			fill_q      <= '0;
			emit_q      <= 1'b0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				keep_q <= cfg_wdata;
			end
			if (accept) begin
				fill_q <= fill_next;
				emit_q <= candidate.last_item;
				rank_q <= '0;
			end else if (step) begin
				rank_q <= rank_q + CW'(1);
				if (step_final) begin
					emit_q <= 1'b0;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_rank_q  <= rank_ext[ksl_pkg::RANK_BITS-1:0];
			out_id_q    <= cell_id[0];
			out_dist_q  <= cell_dist[0];
			out_final_q <= step_final;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.rank          = out_rank_q;
	assign result.kept_id       = out_id_q;
	assign result.kept_distance = out_dist_q;
	assign result.final_entry   = out_final_q;

`ifndef SYNTHESIS
	a_rank_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> (rank_q < fill_q))
		else $error("Emission rank has run past the list fill.");

	a_fill_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fill_q != '0) && (fill_q <= MAX_FILL))
		else $error("List fill is out of range after an add.");

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && step_final) |=> (!emit_q && out_valid_q && out_final_q))
		else $error("Emission did not end on the final entry.");

	a_final_rank: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (out_final_q == ((rank_q == fill_q) && !emit_q)))
		else $error("Final entry flag disagrees with the emission count.");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the k smallest sorted list block, with its own model of the ranked list.
// Needs ksl_pkg, the ksl_in_if and ksl_out_if interfaces and the block's RTL.
`default_nettype none

module tb_top;

	localparam int MAX_KEEP      = ksl_pkg::MAX_KEEP_DEF;
	localparam int ID_W          = ksl_pkg::ID_BITS_DEF;
	localparam int DIST_W        = ksl_pkg::DIST_BITS_DEF;
	localparam int MAX_GAP       = 17;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 300;

	typedef struct packed {
		logic [ID_W-1:0]   record_id;
		logic [DIST_W-1:0] distance;
		logic              first_item;
		logic              last_item;
	} candidate_t;

	typedef struct packed {
		logic [ksl_pkg::RANK_BITS-1:0] rank;
		logic [ID_W-1:0]               kept_id;
		logic [DIST_W-1:0]             kept_distance;
		logic                          final_entry;
	} ranked_entry_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	logic [ksl_pkg::KEEP_BITS-1:0] cfg_wdata;

	ksl_in_if  cand_ch ();
	ksl_out_if res_ch ();

	k_smallest_sorted_list i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_wdata (cfg_wdata),
		.candidate (cand_ch),
		.result    (res_ch)
	);

	logic [ksl_pkg::KEEP_BITS-1:0] keep_setting = ksl_pkg::KEEP_RESET;
	logic [ID_W-1:0]      best_ids   [MAX_KEEP];
	logic [DIST_W-1:0]    best_dists [MAX_KEEP];
	int                   best_fill  = 0;

	ranked_entry_t due_entries [$];
	candidate_t    pending     [$];
	candidate_t    offered;

	int unsigned send_wait;
	int unsigned recv_wait;
	bit          send_idle  = 1'b0;
	bit          recv_idle  = 1'b0;
	bit          hold_armed = 1'b0;
	bit          hold_done;
	bit          recv_block;
	int unsigned hold_count;

	int fail_count     = 0;
	int accepted_count = 0;
	int entry_count    = 0;
	int emit_count     = 0;
	int random_queued  = 0;

	always #2 clk = ~clk;

	function automatic void rank_candidate(candidate_t c);
		int            cap;
		int            slot;
		ranked_entry_t e;
		cap = (keep_setting == 0) ? 1 : ((keep_setting > MAX_KEEP) ? MAX_KEEP : keep_setting);
		if (c.first_item)
			best_fill = 0;
		if (best_fill > cap)
			best_fill = cap;
		slot = best_fill;
		for (int i = best_fill - 1; i >= 0; i--)
			if (c.distance < best_dists[i])
				slot = i;
		if (best_fill < cap || slot < best_fill) begin
			for (int i = (best_fill < cap) ? best_fill : best_fill - 1; i > slot; i--) begin
				best_ids[i]   = best_ids[i-1];
				best_dists[i] = best_dists[i-1];
			end
			best_ids[slot]   = c.record_id;
			best_dists[slot] = c.distance;
			if (best_fill < cap)
				best_fill++;
		end
		if (c.last_item) begin
			for (int i = 0; i < best_fill; i++) begin
				e.rank          = ksl_pkg::RANK_BITS'(i);
				e.kept_id       = best_ids[i];
				e.kept_distance = best_dists[i];
				e.final_entry   = (i == best_fill - 1);
				due_entries.push_back(e);
			end
			emit_count++;
		end
	endfunction

	function automatic void compare_field(string name, logic [DIST_W-1:0] want,
			logic [DIST_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// A new request is taken from the queue only when the previous one has gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_ch.valid      <= 1'b0;
			cand_ch.record_id  <= '0;
			cand_ch.distance   <= '0;
			cand_ch.first_item <= 1'b0;
			cand_ch.last_item  <= 1'b0;
			send_wait          <= 0;
		end else begin
			if (cand_ch.valid && cand_ch.ready) begin
				rank_candidate(offered);
				accepted_count++;
			end
			if (!cand_ch.valid || cand_ch.ready) begin
				if (send_wait != 0) begin
					send_wait     <= send_wait - 1;
					cand_ch.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					offered             = pending.pop_front();
					cand_ch.valid      <= 1'b1;
					cand_ch.record_id  <= offered.record_id;
					cand_ch.distance   <= offered.distance;
					cand_ch.first_item <= offered.first_item;
					cand_ch.last_item  <= offered.last_item;
					send_wait          <= send_idle ? $urandom_range(0, MAX_GAP) : 0;
				end else begin
					cand_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int unsigned   stall;
		ranked_entry_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			stall = recv_wait;
			if (res_ch.valid && res_ch.ready) begin
				entry_count++;
				if (due_entries.size() == 0) begin
					$display("%0t: result with nothing expected, rank %0d id %h distance %h final %b",
						$time, res_ch.rank, res_ch.kept_id, res_ch.kept_distance,
						res_ch.final_entry);
					fail_count++;
				end else begin
					want = due_entries.pop_front();
					compare_field("rank", DIST_W'(want.rank), DIST_W'(res_ch.rank));
					compare_field("kept_id", DIST_W'(want.kept_id), DIST_W'(res_ch.kept_id));
					compare_field("kept_distance", want.kept_distance, res_ch.kept_distance);
					compare_field("final_entry", DIST_W'(want.final_entry),
						DIST_W'(res_ch.final_entry));
				end
				stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
			end else if (stall != 0) begin
				stall--;
			end
			recv_wait    <= stall;
			res_ch.ready <= (stall == 0) && !recv_block;
		end
	end

	// One long hold-off on the result side, so that emission stalls and the block
	// stops taking requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_block <= 1'b0;
			hold_count <= 0;
			hold_done  <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			if (hold_count == HOLD_CYCLES) begin
				recv_block <= 1'b0;
				hold_done  <= 1'b1;
			end else begin
				recv_block <= 1'b1;
				hold_count <= hold_count + 1;
			end
		end
	end

	task automatic write_keep(logic [ksl_pkg::KEEP_BITS-1:0] value);
		@(posedge clk);
		cfg_write    <= 1'b1;
		cfg_wdata    <= value;
		keep_setting  = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_request(logic [ID_W-1:0] id, logic [DIST_W-1:0] dist_val, bit first,
			bit last);
		candidate_t c;
		c.record_id  = id;
		c.distance   = dist_val;
		c.first_item = first;
		c.last_item  = last;
		pending.push_back(c);
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending.size() != 0 || cand_ch.valid || due_entries.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [DIST_W-1:0] pick_distance(int style);
		case (style)
			0:       return DIST_W'($urandom_range(0, 15));
			1:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
			2:       return DIST_W'($urandom) << 16;
			default: return DIST_W'($urandom);
		endcase
	endfunction

	// A list run opens with a request marked first most of the time and closes with one
	// marked last; a few requests carry random marks instead.
	task automatic queue_list(int count);
		int style;
		bit first;
		bit last;
		style = $urandom_range(0, 4);
		for (int i = 0; i < count; i++) begin
			first = (i == 0) && ($urandom_range(0, 3) != 0);
			last  = (i == count - 1);
			if ($urandom_range(0, 7) == 0) begin
				first = 1'($urandom_range(0, 1));
				last  = 1'($urandom_range(0, 1));
			end
			queue_request(ID_W'($urandom), pick_distance(style), first, last);
			random_queued++;
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int phase;
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_wdata          = ksl_pkg::KEEP_RESET;
		cand_ch.valid      = 1'b0;
		cand_ch.record_id  = '0;
		cand_ch.distance   = '0;
		cand_ch.first_item = 1'b0;
		cand_ch.last_item  = 1'b0;
		res_ch.ready       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_request(16'h0000, 32'h0000_0000, 1'b1, 1'b1);
		queue_request(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_request(16'h1234, 32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_request(16'hAAAA, 32'h0000_0000, 1'b0, 1'b0);
		queue_request(16'h5555, 32'h0001_0000, 1'b0, 1'b1);
		drain();
		// The list holds four entries, so the next request first cuts it to three.
		write_keep(4'd3);
		queue_request(16'h0F0F, 32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_request(16'h00F0, 32'h0000_0007, 1'b0, 1'b1);
		drain();
		write_keep(4'd0);
		queue_request(16'h0001, 32'h0000_0005, 1'b1, 1'b0);
		queue_request(16'h0002, 32'h0000_0005, 1'b0, 1'b0);
		queue_request(16'h0003, 32'h0000_0004, 1'b0, 1'b1);
		drain();
		write_keep(4'd15);
		for (int i = 0; i <= 10; i++)
			queue_request(ID_W'(16'h0100 + i), (i % 3 != 0) ? DIST_W'(50 - i) : DIST_W'(50),
				i == 0, i == 10);
		drain();
		write_keep(4'd1);
		queue_request(16'h0007, 32'h0000_0009, 1'b1, 1'b0);
		queue_request(16'h0008, 32'h0000_0008, 1'b0, 1'b1);
		drain();

		write_keep(4'd10);
		hold_armed = 1'b1;
		for (int i = 0; i < 8; i++)
			queue_list(4);
		drain();

		phase = 0;
		while (random_queued < RANDOM_ITEMS) begin
			case (phase)
				0:       write_keep(4'd1);
				1:       write_keep(4'd10);
				2:       write_keep(4'd0);
				3:       write_keep(4'd15);
				default: write_keep(ksl_pkg::KEEP_BITS'($urandom_range(0, 15)));
			endcase
			send_idle = ($urandom_range(0, 2) != 0);
			recv_idle = ($urandom_range(0, 2) != 0);
			repeat ($urandom_range(3, 6))
				queue_list(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
					$urandom_range(4, 16));
			drain();
			phase++;
		end

		$display("Run covered %0d candidate requests, %0d list emissions and %0d ranked entries.",
			accepted_count, emit_count, entry_count);
		$display("Keep counts from zero to fifteen were set, with one long stall on the results.");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
